// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ----- hdl/ttbdd_pkg.sv -----
// ---------------------------------------------------------------------------
// ttbdd_pkg
// Constants, types and helpers of the truth table BDD node counter.
// ---------------------------------------------------------------------------
package ttbdd_pkg;

    localparam int MAX_VARS    = 10;
    localparam int MAX_OUTPUTS = 4;
    localparam int WORD_BITS   = 32;
    localparam int NODE_DEPTH  = 4096;
    localparam int LOG_WORD    = 5;

    localparam int TABLE_DEPTH = MAX_OUTPUTS << (MAX_VARS - LOG_WORD);
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_OUTPUTS << MAX_VARS);
    localparam int CNT_W       = NODE_AW + 1;
    localparam int CODE_W      = IDX_W + 2;
    localparam int LEV_W       = $clog2(MAX_VARS + 1);
    localparam int OUTS_W      = $clog2(MAX_OUTPUTS + 1);
    localparam int WI_W        = MAX_VARS - LOG_WORD;
    localparam int POS_W       = LOG_WORD;
    localparam int WCNT_W      = 8;

    // Fixed field widths.
    localparam int VAR_W   = 4;
    localparam int OUT_W   = 3;
    localparam int CFG_W   = 4;
    localparam int COUNT_W = 13;

    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(4096);

    // Register indexes.
    localparam logic REG_VAR_COUNT    = 1'b0;
    localparam logic REG_OUTPUT_COUNT = 1'b1;

    // Cofactor result codes for the constants.
    localparam logic [CODE_W-1:0] CODE_ZERO = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_ONE  = CODE_W'(1);

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 eq;
        logic                 cp;
        logic                 zero;
        logic                 one;
    } cmp_res_t;

    // Mask of a function of 2^lw minterms held in one word.
    function automatic logic [WORD_BITS-1:0] lw_mask(input logic [LEV_W-1:0] lw);
        logic [WORD_BITS-1:0] m;
        m = 32'hffffffff;
        case (lw)
            LEV_W'(0): m = 32'h00000001;
            LEV_W'(1): m = 32'h00000003;
            LEV_W'(2): m = 32'h0000000f;
            LEV_W'(3): m = 32'h000000ff;
            LEV_W'(4): m = 32'h0000ffff;
            default:   m = 32'hffffffff;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/ttbdd_ram.sv -----
// ---------------------------------------------------------------------------
// ttbdd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ttbdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/ttbdd_cmp.sv -----
// ---------------------------------------------------------------------------
// ttbdd_cmp
// Shared compare unit: extract a function slice from a table word and
// compare it with a reference slice, with its complement and with both constants.
// ---------------------------------------------------------------------------
module ttbdd_cmp import ttbdd_pkg::*; (
    input  logic [WORD_BITS-1:0] word,
    input  logic [POS_W-1:0]     pos,
    input  logic [WORD_BITS-1:0] mask,
    input  logic [WORD_BITS-1:0] ref_word,
    output cmp_res_t             res
);

    logic [WORD_BITS-1:0] v;

    assign v = (word >> pos) & mask;

    always_comb
    begin
        res.value = v;
        res.eq    = (v == ref_word);
        res.cp    = (v == (ref_word ^ mask));
        res.zero  = (v == '0);
        res.one   = (v == mask);
    end

endmodule

// ----- hdl/truth_table_bdd_node_count_core.sv -----
// The transaction with the last word starts the count.
// Each placement first checks its slice against both constants word by word, then compares
// it word by word with each node listed on its level; each parent is read from the node list,
// and the final tally reads every stored node before loading the output register.
// Throughput: one word per cycle while loading; the input stalls for the whole count run.
// Reset clears control state only; every table and node entry read is written first.
// ---------------------------------------------------------------------------
// truth_table_bdd_node_count_core
// Loads a multi-output truth table and counts the nodes of its shared BDD
// with complement edges, using one shared compare unit under a sequencer.
// ---------------------------------------------------------------------------
module truth_table_bdd_node_count_core import ttbdd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_BITS-1:0] table_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COUNT_W-1:0]   node_count,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE, S_CONST_RD, S_CONST_CHK, S_LIST, S_NODE_RD, S_NODE_WAIT,
        S_A_RD, S_A_USE, S_B_RD, S_B_USE, S_MATCH, S_RET,
        S_EXP, S_EXP_WAIT, S_CNT, S_CNT_WAIT, S_FIN
    } state_t;

    // Where a finished placement returns to.
    typedef enum logic [1:0] {RET_L0, RET_C0, RET_C1} ret_t;

    state_t                state_reg, state_next;
    ret_t                  ret_reg, ret_next;
    logic [VAR_W-1:0]      vars_reg, vars_next;
    logic [OUT_W-1:0]      outs_reg, outs_next;
    logic [WCNT_W-1:0]     wcnt_reg, wcnt_next;
    logic [LEV_W-1:0]      lev_reg, lev_next;
    logic [OUTS_W-1:0]     o_reg, o_next;
    logic [CNT_W-1:0]      c_start_reg, c_start_next;   // first node of current level
    logic [CNT_W-1:0]      c_stop_reg, c_stop_next;     // end of current level list
    logic [CNT_W-1:0]      ej_reg, ej_next;             // parent / tally walker
    logic [CNT_W-1:0]      j2_reg, j2_next;             // level list walker
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic [IDX_W-1:0]      pl_idx_reg, pl_idx_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic [IDX_W-1:0]      other_reg, other_next;
    logic [WI_W-1:0]       wi_reg, wi_next;
    logic                  zero_reg, zero_next;
    logic                  one_reg, one_next;
    logic                  eq_reg, eq_next;
    logic                  cp_reg, cp_next;
    logic [WORD_BITS-1:0]  va_reg, va_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [CODE_W-1:0]     c0_reg, c0_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]    node_count_reg, node_count_next;

    // Clamped configuration.
    logic [LEV_W-1:0]      vars_use;
    logic [OUTS_W-1:0]     outs_use;
    logic [WCNT_W-1:0]     words_total;
    logic                  last_word;

    // Slice addressing of the function under test.
    logic [LEV_W-1:0]      lw;
    logic [LEV_W-1:0]      sh;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W+WI_W-1:0] wide_addr;
    logic [POS_W-1:0]      low_bits;
    logic [TAB_AW-1:0]     tab_raddr;
    logic [POS_W-1:0]      pos;
    logic [WORD_BITS-1:0]  mask;
    logic [WI_W-1:0]       last_wi;

    logic [WORD_BITS-1:0]  tab_rdata;
    logic                  tab_we;
    logic                  node_we;
    logic [NODE_AW-1:0]    node_waddr;
    logic [NODE_AW-1:0]    node_raddr;
    logic [IDX_W:0]        node_wdata;
    logic [IDX_W:0]        node_rdata;
    cmp_res_t              cmp;

    logic [CNT_W-1:0]      total;
    logic [COUNT_W-1:0]    result;
    logic                  z_acc, o_acc;
    logic                  count_ok;

    always_comb
    begin
        if (vars_reg < VAR_W'(LOG_WORD))
            vars_use = LEV_W'(LOG_WORD);
        else if (int'(vars_reg) > MAX_VARS)
            vars_use = LEV_W'(MAX_VARS);
        else
            vars_use = LEV_W'(vars_reg);

        if (outs_reg == '0)
            outs_use = OUTS_W'(1);
        else if (int'(outs_reg) > MAX_OUTPUTS)
            outs_use = OUTS_W'(MAX_OUTPUTS);
        else
            outs_use = OUTS_W'(outs_reg);
    end

    assign words_total = WCNT_W'(outs_use) << (vars_use - LEV_W'(LOG_WORD));
    assign last_word   = ({1'b0, wcnt_reg} + (WCNT_W+1)'(1)) >= {1'b0, words_total};

    // Slice of width 2^lw: whole words above the word size, a bit field up to it.
    assign lw       = vars_use - lev_reg;
    assign sh       = LEV_W'(LOG_WORD) - lw;
    assign sel_idx  = (state_reg == S_B_RD || state_reg == S_B_USE) ? other_reg : pl_idx_reg;
    assign mask     = lw_mask(lw);
    assign low_bits = POS_W'(sel_idx) & ((POS_W'(1) << sh) - POS_W'(1));

    always_comb
    begin
        if (lw > LEV_W'(LOG_WORD))
        begin
            wide_addr = ((IDX_W+WI_W)'(sel_idx) << (lw - LEV_W'(LOG_WORD)))
                      + (IDX_W+WI_W)'(wi_reg);
            tab_raddr = wide_addr[TAB_AW-1:0];
            pos       = '0;
            last_wi   = (WI_W'(1) << (lw - LEV_W'(LOG_WORD))) - WI_W'(1);
        end
        else
        begin
            wide_addr = (IDX_W+WI_W)'(sel_idx >> sh);
            tab_raddr = wide_addr[TAB_AW-1:0];
            pos       = POS_W'(low_bits << lw);
            last_wi   = '0;
        end
    end

    assign tab_we = (state_reg == S_IDLE) && in_valid;

    ttbdd_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (wcnt_reg[TAB_AW-1:0]),
        .wdata (table_word),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // Node list entry: redundant mark on top, function index below.
    assign node_raddr = (state_reg == S_NODE_RD) ? j2_reg[NODE_AW-1:0] : ej_reg[NODE_AW-1:0];

    ttbdd_ram #(.WIDTH(IDX_W+1), .DEPTH(NODE_DEPTH)) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    ttbdd_cmp u_cmp (
        .word     (tab_rdata),
        .pos      (pos),
        .mask     (mask),
        .ref_word (va_reg),
        .res      (cmp)
    );

    assign total  = cnt_reg + CNT_W'(1);
    assign result = (ovf_reg || total > CNT_W'(COUNT_CAP)) ? COUNT_CAP : COUNT_W'(total);
    assign z_acc  = zero_reg & cmp.zero;
    assign o_acc  = one_reg & cmp.one;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        vars_next       = vars_reg;
        outs_next       = outs_reg;
        wcnt_next       = wcnt_reg;
        lev_next        = lev_reg;
        o_next          = o_reg;
        c_start_next    = c_start_reg;
        c_stop_next     = c_stop_reg;
        ej_next         = ej_reg;
        j2_next         = j2_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        pl_idx_next     = pl_idx_reg;
        pidx_next       = pidx_reg;
        other_next      = other_reg;
        wi_next         = wi_reg;
        zero_next       = zero_reg;
        one_next        = one_reg;
        eq_next         = eq_reg;
        cp_next         = cp_reg;
        va_next         = va_reg;
        code_next       = code_reg;
        c0_next         = c0_reg;
        node_count_next = node_count_reg;
        node_we         = 1'b0;
        node_waddr      = c_stop_reg[NODE_AW-1:0];
        node_wdata      = {1'b0, pl_idx_reg};

        // Drop the result once the output transaction completes.
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (last_word)
                    begin
                        // Table complete: start with output 0 at the top level.
                        wcnt_next    = '0;
                        c_start_next = '0;
                        c_stop_next  = '0;
                        ovf_next     = 1'b0;
                        lev_next     = '0;
                        o_next       = '0;
                        cnt_next     = '0;
                        pl_idx_next  = '0;
                        wi_next      = '0;
                        zero_next    = 1'b1;
                        one_next     = 1'b1;
                        ret_next     = RET_L0;
                        state_next   = S_CONST_RD;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg + WCNT_W'(1);
                    end
                end
                if (cfg_we)
                begin
                    wcnt_next = '0;
                    case (cfg_index)
                        REG_VAR_COUNT:    vars_next = cfg_data[VAR_W-1:0];
                        REG_OUTPUT_COUNT: outs_next = cfg_data[OUT_W-1:0];
                        default:          vars_next = vars_reg;
                    endcase
                end
            end

            S_CONST_RD:
            begin
                state_next = S_CONST_CHK;
            end

            S_CONST_CHK:
            begin
                zero_next = z_acc;
                one_next  = o_acc;
                if (wi_reg == last_wi)
                begin
                    if (z_acc)
                    begin
                        code_next  = CODE_ZERO;
                        state_next = S_RET;
                    end
                    else if (o_acc)
                    begin
                        code_next  = CODE_ONE;
                        state_next = S_RET;
                    end
                    else
                    begin
                        j2_next    = c_start_reg;
                        state_next = S_LIST;
                    end
                end
                else
                begin
                    wi_next    = wi_reg + WI_W'(1);
                    state_next = S_CONST_RD;
                end
            end

            S_LIST:
            begin
                if (j2_reg < c_stop_reg)
                begin
                    state_next = S_NODE_RD;
                end
                else
                begin
                    // No match: append to this level if there is room.
                    if (c_stop_reg < CNT_W'(NODE_DEPTH))
                    begin
                        node_we     = 1'b1;
                        c_stop_next = c_stop_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    code_next  = (CODE_W'(pl_idx_reg) + CODE_W'(1)) << 1;
                    state_next = S_RET;
                end
            end

            S_NODE_RD:
            begin
                state_next = S_NODE_WAIT;
            end

            S_NODE_WAIT:
            begin
                other_next = node_rdata[IDX_W-1:0];
                wi_next    = '0;
                eq_next    = 1'b1;
                cp_next    = 1'b1;
                state_next = S_A_RD;
            end

            S_A_RD:
            begin
                state_next = S_A_USE;
            end

            S_A_USE:
            begin
                va_next    = cmp.value;
                state_next = S_B_RD;
            end

            S_B_RD:
            begin
                state_next = S_B_USE;
            end

            S_B_USE:
            begin
                eq_next = eq_reg & cmp.eq;
                cp_next = cp_reg & cmp.cp;
                if (wi_reg == last_wi)
                begin
                    state_next = S_MATCH;
                end
                else
                begin
                    wi_next    = wi_reg + WI_W'(1);
                    state_next = S_A_RD;
                end
            end

            S_MATCH:
            begin
                if (eq_reg)
                begin
                    code_next  = (CODE_W'(other_reg) + CODE_W'(1)) << 1;
                    state_next = S_RET;
                end
                else if (cp_reg)
                begin
                    code_next  = ((CODE_W'(other_reg) + CODE_W'(1)) << 1) | CODE_W'(1);
                    state_next = S_RET;
                end
                else
                begin
                    j2_next    = j2_reg + CNT_W'(1);
                    state_next = S_LIST;
                end
            end

            S_RET:
            begin
                wi_next   = '0;
                zero_next = 1'b1;
                one_next  = 1'b1;
                case (ret_reg)
                    RET_L0:
                    begin
                        if (o_reg + OUTS_W'(1) == outs_use)
                        begin
                            // Top level done: expand its nodes into level 1.
                            lev_next     = LEV_W'(1);
                            ej_next      = '0;
                            c_start_next = c_stop_reg;
                            state_next   = S_EXP;
                        end
                        else
                        begin
                            o_next      = o_reg + OUTS_W'(1);
                            pl_idx_next = IDX_W'(o_reg + OUTS_W'(1));
                            state_next  = S_CONST_RD;
                        end
                    end
                    RET_C0:
                    begin
                        c0_next     = code_reg;
                        pl_idx_next = {pidx_reg[IDX_W-2:0], 1'b1};
                        ret_next    = RET_C1;
                        state_next  = S_CONST_RD;
                    end
                    default:
                    begin
                        // Both cofactors alike: mark the parent redundant.
                        if (c0_reg == code_reg)
                        begin
                            node_we    = 1'b1;
                            node_waddr = ej_reg[NODE_AW-1:0];
                            node_wdata = {1'b1, pidx_reg};
                        end
                        ej_next    = ej_reg + CNT_W'(1);
                        state_next = S_EXP;
                    end
                endcase
            end

            S_EXP:
            begin
                if (ej_reg < c_start_reg)
                begin
                    state_next = S_EXP_WAIT;
                end
                else if (lev_reg + LEV_W'(1) == vars_use)
                begin
                    ej_next    = '0;
                    cnt_next   = '0;
                    state_next = S_CNT;
                end
                else
                begin
                    // Advance a level; the walker already sits on its first parent.
                    lev_next     = lev_reg + LEV_W'(1);
                    c_start_next = c_stop_reg;
                end
            end

            S_EXP_WAIT:
            begin
                pidx_next   = node_rdata[IDX_W-1:0];
                pl_idx_next = {node_rdata[IDX_W-2:0], 1'b0};
                wi_next     = '0;
                zero_next   = 1'b1;
                one_next    = 1'b1;
                ret_next    = RET_C0;
                state_next  = S_CONST_RD;
            end

            S_CNT:
            begin
                if (ej_reg < c_stop_reg)
                    state_next = S_CNT_WAIT;
                else
                    state_next = S_FIN;
            end

            S_CNT_WAIT:
            begin
                if (!node_rdata[IDX_W])
                    cnt_next = cnt_reg + CNT_W'(1);
                ej_next    = ej_reg + CNT_W'(1);
                state_next = S_CNT;
            end

            S_FIN:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    node_count_next = result;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_L0;
            vars_reg      <= VAR_W'(10);
            outs_reg      <= OUT_W'(1);
            wcnt_reg      <= '0;
            lev_reg       <= '0;
            o_reg         <= '0;
            c_start_reg   <= '0;
            c_stop_reg    <= '0;
            ej_reg        <= '0;
            j2_reg        <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            wi_reg        <= '0;
            zero_reg      <= 1'b0;
            one_reg       <= 1'b0;
            eq_reg        <= 1'b0;
            cp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            vars_reg      <= vars_next;
            outs_reg      <= outs_next;
            wcnt_reg      <= wcnt_next;
            lev_reg       <= lev_next;
            o_reg         <= o_next;
            c_start_reg   <= c_start_next;
            c_stop_reg    <= c_stop_next;
            ej_reg        <= ej_next;
            j2_reg        <= j2_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            wi_reg        <= wi_next;
            zero_reg      <= zero_next;
            one_reg       <= one_next;
            eq_reg        <= eq_next;
            cp_reg        <= cp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pl_idx_reg     <= pl_idx_next;
        pidx_reg       <= pidx_next;
        other_reg      <= other_next;
        va_reg         <= va_next;
        code_reg       <= code_next;
        c0_reg         <= c0_next;
        node_count_reg <= node_count_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign node_count = node_count_reg;

    assign count_ok = (node_count_reg >= COUNT_W'(1)) && (node_count_reg <= COUNT_CAP);

    `ASSERT_IMPL(a_level_order, 1'b1, c_start_reg <= c_stop_reg, "level start past level end")
    `ASSERT_IMPL(a_count_range, out_valid_reg, count_ok, "node count out of range")
    `ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && last_word && !cfg_we, in_stall, "count did not start after last word")

endmodule
